// ===== src/htfd_pkg.sv =====
// shared types, constants and crc helper for the humidity/temperature frame decoder
package htfd_pkg;

    localparam int unsigned POS_W = 3;

    // byte positions within a six-byte frame
    localparam logic [POS_W-1:0] POS_W0_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_W0_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_W0_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_W1_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_W1_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_W1_CRC = 3'd5;
    localparam logic [POS_W-1:0] FRAME_LEN  = 3'd6;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam logic [13:0]        HUM_SCALE   = 14'd10000;

    localparam logic signed [15:0] TEMP_FAIL = 16'sd25500;
    localparam logic [14:0]        HUM_FAIL  = 15'd25500;

    // both words of a completed frame with their crc verdicts
    typedef struct packed {
        logic [15:0] w0;
        logic        ok0;
        logic [15:0] w1;
        logic        ok1;
    } frame_t;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (crc[7])
            begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== src/htfd_if.sv =====
// request channels of the frame decoder: received bytes in, decoded results out
interface htfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature;
    logic [14:0]        humidity;
    logic               temp_ok;
    logic               hum_ok;

    modport source (output valid, temperature, humidity, temp_ok, hum_ok, input ready);
    modport sink   (input valid, temperature, humidity, temp_ok, hum_ok, output ready);
endinterface

// ===== src/htfd_collect.sv =====
// byte collector: tracks frame position, runs crc per byte, registers completed frames
module htfd_collect (
    input  logic            clk,
    input  logic            rst_n,
    htfd_byte_if.sink       byte_in,
    output htfd_pkg::frame_t frame,
    output logic            frame_valid,
    input  logic            frame_take
);
    import htfd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       b0_reg, b1_reg, b2_reg, b3_reg, b4_reg;
    logic [7:0]       crc_run_reg;
    logic [7:0]       crc0_reg;
    logic [7:0]       crc_step;
    frame_t           frame_reg;
    logic             frame_valid_reg, frame_valid_next;
    logic             accept;

    assign byte_in.ready = !frame_valid_reg || frame_take;
    assign accept        = byte_in.valid && byte_in.ready;

    // restart on frame_start or an impossible position
    assign pos_eff  = (byte_in.frame_start || pos_reg >= FRAME_LEN) ? POS_W0_HI : pos_reg;
    assign crc_step = crc8_byte((pos_eff == POS_W0_HI || pos_eff == POS_W1_HI) ? CRC_INIT
                                                                               : crc_run_reg,
                                byte_in.rx_byte);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = (pos_eff == POS_W1_CRC) ? POS_W0_HI : pos_eff + 3'd1;
        end
        frame_valid_next = frame_valid_reg;
        if (frame_take)
        begin
            frame_valid_next = 1'b0;
        end
        if (accept && pos_eff == POS_W1_CRC)
        begin
            frame_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_W0_HI;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unique case (pos_eff)
                POS_W0_HI:
                begin
                    b0_reg      <= byte_in.rx_byte;
                    crc_run_reg <= crc_step;
                end
                POS_W0_LO:
                begin
                    b1_reg   <= byte_in.rx_byte;
                    crc0_reg <= crc_step;
                end
                POS_W0_CRC:
                begin
                    b2_reg <= byte_in.rx_byte;
                end
                POS_W1_HI:
                begin
                    b3_reg      <= byte_in.rx_byte;
                    crc_run_reg <= crc_step;
                end
                POS_W1_LO:
                begin
                    b4_reg      <= byte_in.rx_byte;
                    crc_run_reg <= crc_step;
                end
                POS_W1_CRC:
                begin
                    frame_reg.w0  <= {b0_reg, b1_reg};
                    frame_reg.ok0 <= (crc0_reg == b2_reg);
                    frame_reg.w1  <= {b3_reg, b4_reg};
                    frame_reg.ok1 <= (crc_run_reg == byte_in.rx_byte);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign frame       = frame_reg;
    assign frame_valid = frame_valid_reg;

endmodule

// ===== src/htfd_convert.sv =====
// word conversion to hundredths with crc fail substitution, into the result register
module htfd_convert (
    input  logic             clk,
    input  logic             rst_n,
    input  htfd_pkg::frame_t frame,
    input  logic             frame_valid,
    output logic             frame_take,
    input  logic             temp_first,
    htfd_result_if.source    result
);
    import htfd_pkg::*;

    logic [15:0]        traw, hraw;
    logic               tok, hok;
    logic [30:0]        tprod;
    logic [29:0]        hprod;
    logic signed [15:0] temp_val;
    logic [14:0]        hum_val;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] temp_reg;
    logic [14:0]        hum_reg;
    logic               tok_reg, hok_reg;

    assign frame_take = frame_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        if (temp_first)
        begin
            traw = frame.w0;
            tok  = frame.ok0;
            hraw = frame.w1;
            hok  = frame.ok1;
        end
        else
        begin
            traw = frame.w1;
            tok  = frame.ok1;
            hraw = frame.w0;
            hok  = frame.ok0;
        end
    end

    assign tprod = {15'd0, traw} * {16'd0, TEMP_SCALE};
    assign hprod = {14'd0, hraw} * {16'd0, HUM_SCALE};

    // scaled values always fit: temp 0..17499 before offset, hum 0..9999
    assign temp_val = tok ? ($signed({1'b0, tprod[30:16]}) - TEMP_OFFSET) : TEMP_FAIL;
    assign hum_val  = hok ? {1'b0, hprod[29:16]} : HUM_FAIL;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (frame_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            temp_reg <= temp_val;
            hum_reg  <= hum_val;
            tok_reg  <= tok;
            hok_reg  <= hok;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.temperature = temp_reg;
    assign result.humidity    = hum_reg;
    assign result.temp_ok     = tok_reg;
    assign result.hum_ok      = hok_reg;

endmodule

// ===== src/humidity_temperature_frame_decoder.sv =====
// Humidity / temperature frame decoder: takes one received byte per clock cycle, gathers
// six-byte frames (word0 high, low, crc, word1 high, low, crc), checks each word with crc-8
// (poly 0x31, init 0xff, msb first) and delivers temperature in 0.01 degC and humidity in
// 0.01 % with per-word ok flags; a failing word reads 25500. frame_start restarts the frame
// on any byte. A byte is taken every cycle as long as results are drained. The sixth byte
// loads the frame register at the accepting edge; the frame then goes through the crc-select
// and one multiplier per word into the result register, which loads and raises the result
// valid once the output is free. Input stalls only when both the frame register and the
// result register are held by a stalled output. cfg_wr_data sets temp_first (reset 1:
// first word is temperature); the user must write it only while idle, the block does not enforce it.
module humidity_temperature_frame_decoder (
    input  logic          clk,
    input  logic          rst_n,
    htfd_byte_if.sink     byte_in,
    htfd_result_if.source result,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);
    import htfd_pkg::*;

    frame_t frame;
    logic   frame_valid;
    logic   frame_take;
    logic   temp_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_first_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            temp_first_reg <= cfg_wr_data;
        end
    end

    htfd_collect u_collect (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (byte_in),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_take  (frame_take)
    );

    htfd_convert u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .frame_valid (frame_valid),
        .frame_take  (frame_take),
        .temp_first  (temp_first_reg),
        .result      (result)
    );

endmodule
